>>> src/ssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared sizes, codes and controller/datapath bundles of the swap slot manager.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int SLOT_COUNT    = 512;

	localparam int ENTRY_W = $clog2(TABLE_ENTRIES);
	localparam int SIDX_W  = $clog2(SLOT_COUNT);

	localparam int OP_W     = 2;
	localparam int PAGE_W   = 52;
	localparam int PID_W    = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 9;
	localparam int FREED_W  = 9;
	localparam int USED_W   = 10;

	localparam logic [OP_W-1:0] OP_SWAP_OUT = 2'd0;
	localparam logic [OP_W-1:0] OP_SWAP_IN  = 2'd1;
	localparam logic [OP_W-1:0] OP_INVAL    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [PID_W-1:0]  pid;
		logic [SIDX_W-1:0] slot;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic                load;       // latch request, clear results
		logic                bm_clr;     // clear pass write at scan index
		logic                sidx_step;  // advance scan index, clear pass
		logic                sidx_init;  // scan index from pointer
		logic                sprobe_step;// next bitmap probe
		logic                bm_rd_scan; // read bitmap at scan index
		logic                bm_rd_rel;  // read bitmap at release slot
		logic                take;       // claim slot at scan index
		logic                eidx_clr;
		logic                eidx_step;
		logic                place;      // fill free entry with request
		logic                rel_got;    // release the claimed slot
		logic                tbl_rd;     // read table entry at entry index
		logic                hit;        // remove matched entry
		logic                rel_clear;  // clear bitmap bit if it is set
		logic                set_status;
		logic [STATUS_W-1:0] status;
		logic                push;       // move results to output register
	} ssm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic            bm_bit;
		logic            sidx_last;
		logic            sprobe_last;
		logic            entry_last;
		logic            entry_free;
		logic            match;
		logic [OP_W-1:0] op;
	} ssm_stat_t;

endpackage

>>> src/ssm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_req_if / ssm_rsp_if
// Valid/ready channels for requests and responses of the swap slot manager.
// ----------------------------------------------------------------------------
interface ssm_req_if;
	logic                         valid;
	logic                         ready;
	logic [ssm_pkg::OP_W-1:0]     op;
	logic [ssm_pkg::PAGE_W-1:0]   page_number;
	logic [ssm_pkg::PID_W-1:0]    process_id;

	modport source (output valid, op, page_number, process_id, input ready);
	modport sink   (input valid, op, page_number, process_id, output ready);
endinterface

interface ssm_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ssm_pkg::STATUS_W-1:0] status;
	logic [ssm_pkg::SLOT_W-1:0]   slot;
	logic [ssm_pkg::FREED_W-1:0]  freed_count;
	logic [ssm_pkg::USED_W-1:0]   used_slots;

	modport source (output valid, status, slot, freed_count, used_slots, input ready);
	modport sink   (input valid, status, slot, freed_count, used_slots, output ready);
endinterface

>>> src/ssm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_ctrl
// Sequencer: clear pass, bitmap probe, table scans, slot release, response.
// ----------------------------------------------------------------------------
module ssm_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic [ssm_pkg::OP_W-1:0] req_op,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	input  ssm_pkg::ssm_stat_t       stat,
	output ssm_pkg::ssm_cmd_t        cmd
);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_BM_RD  = 4'd2;
	localparam logic [3:0] S_BM_CHK = 4'd3;
	localparam logic [3:0] S_E_FREE = 4'd4;
	localparam logic [3:0] S_E_RD   = 4'd5;
	localparam logic [3:0] S_E_CMP  = 4'd6;
	localparam logic [3:0] S_R_RD   = 4'd7;
	localparam logic [3:0] S_R_CHK  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       push;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign push      = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.bm_clr    = 1'b1;
				cmd.sidx_step = 1'b1;
				if (stat.sidx_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load     = 1'b1;
					cmd.eidx_clr = 1'b1;
					case (req_op)
						ssm_pkg::OP_SWAP_OUT: begin
							cmd.sidx_init = 1'b1;
							state_d       = S_BM_RD;
						end
						ssm_pkg::OP_SWAP_IN: state_d = S_E_RD;
						ssm_pkg::OP_INVAL:   state_d = S_E_RD;
						default:             state_d = S_DONE;
					endcase
				end
			end
			S_BM_RD: begin
				cmd.bm_rd_scan = 1'b1;
				state_d        = S_BM_CHK;
			end
			S_BM_CHK: begin
				if (!stat.bm_bit) begin
					cmd.take = 1'b1;
					state_d  = S_E_FREE;
				end else if (stat.sprobe_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = ssm_pkg::ST_NO_SPACE;
					state_d        = S_DONE;
				end else begin
					cmd.sprobe_step = 1'b1;
					state_d         = S_BM_RD;
				end
			end
			S_E_FREE: begin
				if (stat.entry_free) begin
					cmd.place = 1'b1;
					state_d   = S_DONE;
				end else if (stat.entry_last) begin
					cmd.rel_got    = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = ssm_pkg::ST_NO_SPACE;
					state_d        = S_R_RD;
				end else begin
					cmd.eidx_step = 1'b1;
				end
			end
			S_E_RD: begin
				cmd.tbl_rd = 1'b1;
				state_d    = S_E_CMP;
			end
			S_E_CMP: begin
				if (stat.match) begin
					cmd.hit = 1'b1;
					state_d = S_R_RD;
				end else if (stat.entry_last) begin
					if (stat.op == ssm_pkg::OP_SWAP_IN) begin
						cmd.set_status = 1'b1;
						cmd.status     = ssm_pkg::ST_NOT_FOUND;
					end
					state_d = S_DONE;
				end else begin
					cmd.eidx_step = 1'b1;
					state_d       = S_E_RD;
				end
			end
			S_R_RD: begin
				cmd.bm_rd_rel = 1'b1;
				state_d       = S_R_CHK;
			end
			S_R_CHK: begin
				cmd.rel_clear = 1'b1;
				// invalidate keeps scanning after each removed entry
				if (stat.op != ssm_pkg::OP_INVAL || stat.entry_last) begin
					state_d = S_DONE;
				end else begin
					cmd.eidx_step = 1'b1;
					state_d       = S_E_RD;
				end
			end
			S_DONE: begin
				cmd.push = push;
				if (push) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

>>> src/ssm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_datapath
// Slot bitmap memory, page table memory, valid bits, counters and results.
// ----------------------------------------------------------------------------
module ssm_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssm_pkg::ssm_cmd_t            cmd,
	input  logic [ssm_pkg::OP_W-1:0]     req_op,
	input  logic [ssm_pkg::PAGE_W-1:0]   req_page,
	input  logic [ssm_pkg::PID_W-1:0]    req_pid,
	output ssm_pkg::ssm_stat_t           stat,
	output logic [ssm_pkg::STATUS_W-1:0] rsp_status,
	output logic [ssm_pkg::SLOT_W-1:0]   rsp_slot,
	output logic [ssm_pkg::FREED_W-1:0]  rsp_freed,
	output logic [ssm_pkg::USED_W-1:0]   rsp_used
);

	localparam logic [ssm_pkg::SIDX_W-1:0]  SIDX_LAST  = ssm_pkg::SIDX_W'(ssm_pkg::SLOT_COUNT - 1);
	localparam logic [ssm_pkg::ENTRY_W-1:0] ENTRY_LAST =
		ssm_pkg::ENTRY_W'(ssm_pkg::TABLE_ENTRIES - 1);

	logic                  bm_mem [ssm_pkg::SLOT_COUNT];
	ssm_pkg::entry_t       tbl_mem [ssm_pkg::TABLE_ENTRIES];
	logic [ssm_pkg::TABLE_ENTRIES-1:0] valid_q;

	logic [ssm_pkg::OP_W-1:0]     op_q;
	logic [ssm_pkg::PAGE_W-1:0]   page_q;
	logic [ssm_pkg::PID_W-1:0]    pid_q;
	logic [ssm_pkg::SIDX_W-1:0]   sidx_q, sprobe_q, ptr_q, got_q, rel_q;
	logic [ssm_pkg::ENTRY_W-1:0]  eidx_q;
	logic [ssm_pkg::USED_W-1:0]   used_q;
	logic                         bm_q;
	ssm_pkg::entry_t              tbl_q;
	logic                         tv_q;
	logic [ssm_pkg::STATUS_W-1:0] res_status_q;
	logic [ssm_pkg::SIDX_W-1:0]   res_slot_q;
	logic [ssm_pkg::FREED_W-1:0]  res_freed_q;
	logic [ssm_pkg::SIDX_W-1:0]   sidx_next;
	logic                         bm_we, bm_wd;
	logic [ssm_pkg::SIDX_W-1:0]   bm_wa, bm_ra;
	logic                         do_release;

	assign sidx_next  = (sidx_q == SIDX_LAST) ? '0 : sidx_q + 1'b1;
	assign do_release = cmd.rel_clear && bm_q;

	always_comb begin
		bm_we = 1'b0;
		bm_wd = 1'b0;
		bm_wa = sidx_q;
		if (cmd.bm_clr) begin
			bm_we = 1'b1;
		end else if (cmd.take) begin
			bm_we = 1'b1;
			bm_wd = 1'b1;
		end else if (do_release) begin
			bm_we = 1'b1;
			bm_wa = rel_q;
		end
	end

	assign bm_ra = cmd.bm_rd_rel ? rel_q : sidx_q;

	always_ff @(posedge clk) begin
		if (bm_we) bm_mem[bm_wa] <= bm_wd;
		if (cmd.bm_rd_scan || cmd.bm_rd_rel) bm_q <= bm_mem[bm_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.place) tbl_mem[eidx_q] <= '{page: page_q, pid: pid_q, slot: got_q};
		if (cmd.tbl_rd) begin
			tbl_q <= tbl_mem[eidx_q];
			tv_q  <= valid_q[eidx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			sidx_q  <= '0;
			ptr_q   <= '0;
			used_q  <= '0;
		end else begin
			if (cmd.place) valid_q[eidx_q] <= 1'b1;
			if (cmd.hit)   valid_q[eidx_q] <= 1'b0;
			if (cmd.sidx_init) sidx_q <= ptr_q;
			else if (cmd.sidx_step || cmd.sprobe_step) sidx_q <= sidx_next;
			if (cmd.take) begin
				ptr_q  <= sidx_next;
				used_q <= used_q + 1'b1;
			end else if (do_release && used_q != '0) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= req_op;
			page_q       <= req_page;
			pid_q        <= req_pid;
			res_status_q <= ssm_pkg::ST_OK;
			res_slot_q   <= '0;
			res_freed_q  <= '0;
		end
		if (cmd.sidx_init) sprobe_q <= '0;
		else if (cmd.sprobe_step) sprobe_q <= sprobe_q + 1'b1;
		if (cmd.eidx_clr) eidx_q <= '0;
		else if (cmd.eidx_step) eidx_q <= eidx_q + 1'b1;
		if (cmd.take) got_q <= sidx_q;
		if (cmd.place) res_slot_q <= got_q;
		if (cmd.rel_got) rel_q <= got_q;
		if (cmd.hit) begin
			rel_q <= tbl_q.slot;
			if (op_q == ssm_pkg::OP_SWAP_IN) res_slot_q <= tbl_q.slot;
			else res_freed_q <= res_freed_q + 1'b1;
		end
		if (cmd.set_status) res_status_q <= cmd.status;
		if (cmd.push) begin
			rsp_status <= res_status_q;
			rsp_slot   <= ssm_pkg::SLOT_W'(res_slot_q);
			rsp_freed  <= res_freed_q;
			rsp_used   <= used_q;
		end
	end

	always_comb begin
		stat.bm_bit      = bm_q;
		stat.sidx_last   = (sidx_q == SIDX_LAST);
		stat.sprobe_last = (sprobe_q == SIDX_LAST);
		stat.entry_last  = (eidx_q == ENTRY_LAST);
		stat.entry_free  = !valid_q[eidx_q];
		stat.op          = op_q;
		stat.match       = tv_q && (tbl_q.pid == pid_q) &&
			(op_q == ssm_pkg::OP_INVAL || tbl_q.page == page_q);
	end

endmodule

>>> src/swap_slot_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_manager_top
// Next-fit swap slot allocator with a page/process to slot table.
// ----------------------------------------------------------------------------
// After reset the block clears its slot bitmap memory, one slot a cycle, and
// takes no request until all SLOT_COUNT (512) slots are cleared. One request
// is worked at a time, and each bitmap probe or table compare goes through a
// registered memory read. Swap out probes up to SLOT_COUNT slots in next-fit
// order and then searches up to TABLE_ENTRIES entries for a free one; swap in
// scans the table until a match; invalidate scans the whole table and
// releases the slot of each entry removed. The response sits in an output
// register, so the next request is taken while it waits.
module swap_slot_manager_top (
	input logic      clk,
	input logic      arst_n,
	ssm_req_if.sink  req,
	ssm_rsp_if.source rsp
);

	ssm_pkg::ssm_cmd_t  cmd;
	ssm_pkg::ssm_stat_t stat;

	ssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_op     (req.op),
		.req_page   (req.page_number),
		.req_pid    (req.process_id),
		.stat       (stat),
		.rsp_status (rsp.status),
		.rsp_slot   (rsp.slot),
		.rsp_freed  (rsp.freed_count),
		.rsp_used   (rsp.used_slots)
	);

endmodule

>>> src/ssm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the swap slot manager responses.
// ----------------------------------------------------------------------------
module ssm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [ssm_pkg::STATUS_W-1:0] rsp_status,
	input logic [ssm_pkg::SLOT_W-1:0]   rsp_slot,
	input logic [ssm_pkg::FREED_W-1:0]  rsp_freed,
	input logic [ssm_pkg::USED_W-1:0]   rsp_used
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_used))
		else $error("response dropped or changed while stalled");

	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_used <= ssm_pkg::USED_W'(ssm_pkg::SLOT_COUNT))
		else $error("used slot count above slot count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ssm_pkg::ST_NO_SPACE ||
			rsp_status == ssm_pkg::ST_NOT_FOUND) |-> rsp_slot == '0 && rsp_freed == '0)
		else $error("failed request reports a slot or a count");

	a_freed_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_freed <= ssm_pkg::FREED_W'(ssm_pkg::TABLE_ENTRIES))
		else $error("freed count above table size");

endmodule

bind swap_slot_manager_top ssm_checker u_ssm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_slot   (rsp.slot),
	.rsp_freed  (rsp.freed_count),
	.rsp_used   (rsp.used_slots)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the swap slot manager. Randomly spaced request beats carry
// swap outs, swap ins, invalidates and an unused op code. A local copy of the slot bitmap and
// page table predicts each response. Responses are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
	import ssm_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [PAGE_W-1:0] page;
		logic [PID_W-1:0]  pid;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [FREED_W-1:0]  freed;
		logic [USED_W-1:0]   used;
	} rsp_t;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int              LIMIT     = 10000000;

	logic clk;
	logic arst_n;

	ssm_req_if req ();
	ssm_rsp_if rsp ();

	swap_slot_manager_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// predicted state
	bit                tbl_valid [TABLE_ENTRIES];
	logic [PAGE_W-1:0] tbl_page  [TABLE_ENTRIES];
	logic [PID_W-1:0]  tbl_pid   [TABLE_ENTRIES];
	int                tbl_slot  [TABLE_ENTRIES];
	bit                slot_map  [SLOT_COUNT];
	int                next_ptr;
	int                in_use;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	// pages sent for swap out, used to aim swap ins at likely hits
	req_t live_pages[$];

	int  mismatches;
	int  cycles;
	bit  stim_done;
	int  send_gap;
	int  recv_gap;
	int  hold_cycles;
	bit  hold_armed;
	int  accepted;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void free_slot(int s);
		if (slot_map[s]) begin
			slot_map[s] = 1'b0;
			if (in_use > 0)
				in_use--;
		end
	endfunction

	function automatic rsp_t predict_rsp(req_t r);
		rsp_t o;
		int   idx;
		int   got;
		bit   placed;
		o = '0;
		if (r.op == OP_SWAP_OUT) begin
			got = -1;
			idx = next_ptr;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (!slot_map[idx]) begin
					got = idx;
					break;
				end
				idx = (idx + 1) % SLOT_COUNT;
			end
			if (got < 0) begin
				o.status = ST_NO_SPACE;
			end else begin
				slot_map[got] = 1'b1;
				in_use++;
				next_ptr = (got + 1) % SLOT_COUNT;
				placed = 1'b0;
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (!tbl_valid[i]) begin
						tbl_valid[i] = 1'b1;
						tbl_page[i] = r.page;
						tbl_pid[i] = r.pid;
						tbl_slot[i] = got;
						placed = 1'b1;
						break;
					end
				end
				if (placed) begin
					o.slot = got[SLOT_W-1:0];
				end else begin
					free_slot(got);
					o.status = ST_NO_SPACE;
				end
			end
		end else if (r.op == OP_SWAP_IN) begin
			o.status = ST_NOT_FOUND;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (tbl_valid[i] && tbl_page[i] == r.page && tbl_pid[i] == r.pid) begin
					o.slot = tbl_slot[i][SLOT_W-1:0];
					free_slot(tbl_slot[i]);
					tbl_valid[i] = 1'b0;
					o.status = ST_OK;
					break;
				end
			end
		end else if (r.op == OP_INVAL) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (tbl_valid[i] && tbl_pid[i] == r.pid) begin
					free_slot(tbl_slot[i]);
					tbl_valid[i] = 1'b0;
					o.freed++;
				end
			end
		end
		o.used = in_use[USED_W-1:0];
		return o;
	endfunction

	function automatic req_t make_req(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
			logic [PID_W-1:0] pid);
		req_t r;
		r.op = op;
		r.page = page;
		r.pid = pid;
		return r;
	endfunction

	function automatic logic [PAGE_W-1:0] rand_page();
		return PAGE_W'({$urandom, $urandom});
	endfunction

	// few processes and pages so hits and invalidates matter
	function automatic req_t rand_req();
		req_t r;
		int   k;
		int   j;
		k = $urandom_range(0, 99);
		r.pid = PID_W'($urandom_range(0, 5));
		r.page = PAGE_W'($urandom_range(0, 40));
		if (k < 5) begin
			r.page = rand_page();
			r.pid = PID_W'($urandom);
		end
		if (k < 55) begin
			r.op = OP_SWAP_OUT;
		end else if (k < 85) begin
			r.op = OP_SWAP_IN;
			if (live_pages.size() > 0 && $urandom_range(0, 3) != 0) begin
				j = $urandom_range(0, live_pages.size() - 1);
				r.page = live_pages[j].page;
				r.pid = live_pages[j].pid;
			end
		end else if (k < 97) begin
			r.op = OP_INVAL;
		end else begin
			r.op = OP_UNUSED;
		end
		if (r.op == OP_SWAP_OUT)
			live_pages.push_back(r);
		return r;
	endfunction

	initial begin
		req_t r;
		for (int i = 0; i < 4; i++)
			pending_reqs.push_back(make_req(OP_SWAP_OUT, {PAGE_W{1'b1}}, {PID_W{1'b1}}));
		pending_reqs.push_back(make_req(OP_SWAP_OUT, '0, '0));
		pending_reqs.push_back(make_req(OP_SWAP_IN, {PAGE_W{1'b1}}, {PID_W{1'b1}}));
		pending_reqs.push_back(make_req(OP_SWAP_IN, '0, '0));
		pending_reqs.push_back(make_req(OP_SWAP_IN, '0, '0));
		pending_reqs.push_back(make_req(OP_SWAP_IN, 52'h5555555555555, 16'haaaa));
		pending_reqs.push_back(make_req(OP_INVAL, '0, {PID_W{1'b1}}));
		pending_reqs.push_back(make_req(OP_INVAL, '0, 16'h1234));
		pending_reqs.push_back(make_req(OP_UNUSED, 52'haaaaaaaaaaaaa, 16'h5555));
		pending_reqs.push_back(make_req(OP_SWAP_OUT, 52'haaaaaaaaaaaaa, 16'h5555));
		pending_reqs.push_back(make_req(OP_SWAP_OUT, 52'h5555555555555, 16'haaaa));
		pending_reqs.push_back(make_req(OP_INVAL, '0, 16'h5555));
		for (int i = 0; i < 180; i++) begin
			r = rand_req();
			pending_reqs.push_back(r);
		end
		// fill the table past full, then take slots away again
		for (int i = 0; i < 262; i++)
			pending_reqs.push_back(make_req(OP_SWAP_OUT, PAGE_W'(i), 16'h0007));
		for (int i = 0; i < 250; i++)
			pending_reqs.push_back(make_req(OP_SWAP_OUT, PAGE_W'(i), 16'h0008));
		pending_reqs.push_back(make_req(OP_INVAL, '0, 16'h0007));
		for (int i = 0; i < 90; i++) begin
			r = rand_req();
			pending_reqs.push_back(r);
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= '0;
			req.page_number <= '0;
			req.process_id <= '0;
			send_gap <= 0;
		end else if (!(req.valid && !req.ready)) begin
			if (req.valid && req.ready) begin
				expected_rsps.push_back(predict_rsp({req.op, req.page_number, req.process_id}));
				accepted <= accepted + 1;
			end
			if (send_gap > 0) begin
				req.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() > 0) begin
				req_t r;
				r = pending_reqs.pop_front();
				req.valid <= 1'b1;
				req.op <= r.op;
				req.page_number <= r.page;
				req.process_id <= r.pid;
				send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
					(($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) :
					$urandom_range(1, 4));
			end else begin
				req.valid <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	// monitor and response stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap <= 0;
			hold_cycles <= 0;
			hold_armed <= 1'b1;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_t want;
				rsp_t got;
				got = {rsp.status, rsp.slot, rsp.freed_count, rsp.used_slots};
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response beat %p", got);
				end else begin
					want = expected_rsps.pop_front();
					if (want !== got) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			// one long hold-off while requests keep coming
			if (hold_armed && accepted == 30) begin
				hold_armed <= 1'b0;
				hold_cycles <= 20000;
				rsp.ready <= 1'b0;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				rsp.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 9) < 3)
					recv_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) :
						$urandom_range(1, 4);
			end
		end
	end

	initial begin
		mismatches = 0;
		accepted = 0;
		stim_done = 1'b0;
		cycles = 0;
		next_ptr = 0;
		in_use = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			tbl_valid[i] = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++)
			slot_map[i] = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL swap_slot_manager_top");
			$finish;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		wait (stim_done && expected_rsps.size() == 0);
		repeat (2000) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("PASS swap_slot_manager_top");
		end else begin
			$display("FAIL swap_slot_manager_top");
		end
		$finish;
	end
endmodule
